/* hw/rtl/bwr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_pkg
// Types, constants and helpers shared by the bit width repacker modules.
// ----------------------------------------------------------------------------
package bwr_pkg;

   localparam int SYM_W   = 8;
   localparam int WIDTH_W = 4;
   localparam int BUF_W   = 15;
   localparam int CNT_W   = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH = 1'd1;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 4'd8;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 4'd8;
   localparam logic [CNT_W-1:0]   MAX_RESULTS = 4'd8;

   // one queued item: merged bits, output width, number of results and last flag
   typedef struct packed {
      logic [BUF_W-1:0]   bits;
      logic [WIDTH_W-1:0] out_width;
      logic [CNT_W-1:0]   num_out;
      logic               last;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type data;
   } push_type;

   typedef struct packed {
      logic      empty;
      logic      full;
      entry_type head;
   } queue_status_type;

   function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
      logic [WIDTH_W-1:0] r;
      if (w == '0) begin
         r = 4'd1;
      end else if (w > WIDTH_MAX) begin
         r = WIDTH_MAX;
      end else begin
         r = w;
      end
      return r;
   endfunction

   function automatic logic [SYM_W-1:0] low_mask(input logic [WIDTH_W-1:0] w);
      logic [SYM_W:0] m;
      m = (9'd1 << w) - 9'd1;
      return m[SYM_W-1:0];
   endfunction

endpackage

/* hw/rtl/bwr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_front
// Accepts input items, merges their bits into the pending buffer and works
// out how many result symbols each item produces.
// ----------------------------------------------------------------------------
module bwr_front
   import bwr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [SYM_W-1:0]   req_in_symbol,
   input  logic               req_in_last,
   input  logic [WIDTH_W-1:0] in_width,
   input  logic [WIDTH_W-1:0] out_width,
   input  logic               queue_full,
   output push_type           push
);

   logic [BUF_W-1:0]   buf_ff;
   logic [BUF_W-1:0]   buf_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [WIDTH_W-1:0] iw;
   logic [WIDTH_W-1:0] ow;
   logic [SYM_W-1:0]   sym;
   logic [BUF_W-1:0]   merged;
   logic [CNT_W-1:0]   total;
   logic [CNT_W-1:0]   rem;
   logic [CNT_W-1:0]   nfull;
   logic [CNT_W-1:0]   used;
   logic               tail;
   logic [CNT_W-1:0]   num_out;
   logic               accept;

   always_comb begin
      iw     = eff_width(in_width);
      ow     = eff_width(out_width);
      sym    = req_in_symbol & low_mask(iw);
      merged = buf_ff | (BUF_W'(sym) << cnt_ff);
      total  = cnt_ff + iw;
      // full symbols: largest k up to eight with k * ow <= total, compared in parallel
      nfull  = '0;
      for (int k = 1; k <= 8; k++) begin
         if ((7'(k) * 7'(ow)) <= 7'(total)) begin
            nfull = CNT_W'(k);
         end
      end
      used    = nfull * ow;
      rem     = total - used;
      tail    = req_in_last && (rem != '0) && (nfull < MAX_RESULTS);
      num_out = nfull + CNT_W'(tail);
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign push.push           = accept && (num_out != '0);
   assign push.data.bits      = merged;
   assign push.data.out_width = ow;
   assign push.data.num_out   = num_out;
   assign push.data.last      = req_in_last;

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_in_last) begin
            buf_in = '0;
            cnt_in = '0;
         end else begin
            buf_in = merged >> used;
            cnt_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
         cnt_ff <= '0;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hw/rtl/bwr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_queue
// Small first-in first-out queue of pending items between front and back.
// ----------------------------------------------------------------------------
module bwr_queue
   import bwr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

   entry_type          mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff;
   logic [CNT_QW-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign do_push = push.push && (count_ff != FULL_CNT);
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign status.head  = mem[rd_ptr_ff];

endmodule

/* hw/rtl/bwr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwr_back
// Drains the head item to the output register, one symbol per unstalled cycle.
// ----------------------------------------------------------------------------
module bwr_back
   import bwr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SYM_W-1:0] rsp_out_symbol,
   output logic             rsp_out_last
);

   logic               started_ff;
   logic               started_in;
   logic [BUF_W-1:0]   prog_buf_ff;
   logic [BUF_W-1:0]   prog_buf_in;
   logic [CNT_W-1:0]   prog_left_ff;
   logic [CNT_W-1:0]   prog_left_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [SYM_W-1:0]   rsp_symbol_ff;
   logic [SYM_W-1:0]   rsp_symbol_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;
   logic [BUF_W-1:0]   cur_buf;
   logic [CNT_W-1:0]   cur_left;
   logic               fire;

   assign cur_buf  = started_ff ? prog_buf_ff : status.head.bits;
   assign cur_left = started_ff ? prog_left_ff : status.head.num_out;
   assign fire     = !status.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop      = fire && (cur_left == 4'd1);

   always_comb begin
      started_in    = started_ff;
      prog_buf_in   = prog_buf_ff;
      prog_left_in  = prog_left_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      if (fire) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = cur_buf[SYM_W-1:0] & low_mask(status.head.out_width);
         rsp_last_in   = status.head.last && (cur_left == 4'd1);
         if (cur_left == 4'd1) begin
            started_in = 1'b0;
         end else begin
            started_in   = 1'b1;
            prog_buf_in  = cur_buf >> status.head.out_width;
            prog_left_in = cur_left - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prog_buf_ff   <= prog_buf_in;
      prog_left_ff  <= prog_left_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_symbol = rsp_symbol_ff;
   assign rsp_out_last   = rsp_last_ff;

endmodule

/* hw/rtl/bit_width_repacker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_width_repacker
// LSB-first gearbox that repacks a symbol stream from one bit width to
// another, flushing zero padded leftover bits on the last item.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    req_in_symbol[7:0], req_in_last
// rsp      out        rsp_valid/stall    rsp_out_symbol[7:0], rsp_out_last
// csr      in         csr_valid/ready    csr_index[0], csr_wdata[3:0]
//
// An item is taken every cycle while the item queue (QUEUE_DEPTH) has room.
// The back end emits one result per cycle while rsp is not stalled; an item
// passes through the item queue and then the output register before reaching rsp.
// Reset is synchronous and clears buffer, queue and output valid flag, and sets both widths to 8.
// A stall on rsp only backs up the queue; req stalls once the queue is full.
// ----------------------------------------------------------------------------
module bit_width_repacker
   import bwr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SYM_W-1:0]     req_in_symbol,
   input  logic                 req_in_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SYM_W-1:0]     rsp_out_symbol,
   output logic                 rsp_out_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WIDTH_W-1:0]   csr_wdata
);

   logic [WIDTH_W-1:0] in_width_ff;
   logic [WIDTH_W-1:0] in_width_in;
   logic [WIDTH_W-1:0] out_width_ff;
   logic [WIDTH_W-1:0] out_width_in;
   push_type           push;
   queue_status_type   status;
   logic               pop;

   assign csr_ready = 1'b1;

   always_comb begin
      in_width_in  = in_width_ff;
      out_width_in = out_width_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IN_WIDTH:  in_width_in  = csr_wdata;
            CSR_OUT_WIDTH: out_width_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= WIDTH_RESET;
         out_width_ff <= WIDTH_RESET;
      end else begin
         in_width_ff  <= in_width_in;
         out_width_ff <= out_width_in;
      end
   end

   bwr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_symbol (req_in_symbol),
      .req_in_last   (req_in_last),
      .in_width      (in_width_ff),
      .out_width     (out_width_ff),
      .queue_full    (status.full),
      .push          (push)
   );

   bwr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (status)
   );

   bwr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .status         (status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_out_last   (rsp_out_last)
   );

endmodule

/* sim/bit_width_repacker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_width_repacker_test
// Self-checking bench for the LSB-first bit width repacker. A directed table
// covers reset widths, out-of-range width codes, the eight-result cap, flush
// with and without leftover bits, and width changes mid-stream. Random
// streams with random widths follow. Every result is checked against the table
// or a local repacking model, with random idles on both channels except in one quiet phase.
// ----------------------------------------------------------------------------
module bit_width_repacker_test;
   import bwr_pkg::*;

   localparam int NUM_DIR        = 18;
   localparam int RANDOM_ITEMS   = 292;
   localparam int STALL_PCT      = 32;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             last;
   } sym_result_type;

   typedef struct packed {
      logic               cfg;
      logic [WIDTH_W-1:0] iw;
      logic [WIDTH_W-1:0] ow;
      logic [SYM_W-1:0]   sym;
      logic               last;
      logic               typed;
      logic [SYM_W-1:0]   exp_sym;
      logic               exp_last;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [SYM_W-1:0]     req_in_symbol;
   logic                 req_in_last;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [SYM_W-1:0]     rsp_out_symbol;
   logic                 rsp_out_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WIDTH_W-1:0]   csr_wdata;

   // local copy of the block state and registers
   logic [WIDTH_W-1:0] cfg_in_width;
   logic [WIDTH_W-1:0] cfg_out_width;
   logic [14:0]        pend_bits;
   logic [3:0]         pend_cnt;

   // newest expected result at the front, oldest at the back
   sym_result_type pending_syms[$];
   sym_result_type head_res;
   int             fail_cnt = 0;
   int             idle_cycles = 0;
   bit             quiet_run = 1'b0;

   // cfg, in_width, out_width, symbol, last, typed, expected symbol, expected last
   dir_row_type dir_rows [NUM_DIR] = '{
      '{1'b0, 4'd8,  4'd8,  8'hA5, 1'b0, 1'b1, 8'hA5, 1'b0},
      '{1'b0, 4'd8,  4'd8,  8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
      '{1'b0, 4'd8,  4'd8,  8'h00, 1'b1, 1'b1, 8'h00, 1'b1},
      '{1'b1, 4'd0,  4'd15, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 4'd0,  4'd15, 8'hFE, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b1, 4'd8,  4'd1,  8'h96, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 4'd8,  4'd1,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b1, 4'd3,  4'd5,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 4'd3,  4'd5,  8'h05, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b1, 4'd7,  4'd2,  8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 4'd7,  4'd2,  8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b1, 4'd7,  4'd8,  8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b1, 4'd8,  4'd1,  8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 4'd8,  4'd1,  8'h3C, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b1, 4'd15, 4'd0,  8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b1, 4'd1,  4'd1,  8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, 4'd1,  4'd1,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b1, 4'd5,  4'd8,  8'h1F, 1'b1, 1'b0, 8'h00, 1'b0}
   };

   bit_width_repacker dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_symbol  (req_in_symbol),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_out_last   (rsp_out_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // 0 acts as 1, codes above 8 act as 8
   function automatic int clip_width(input logic [WIDTH_W-1:0] w);
      if (w == 4'd0) begin
         return 1;
      end else if (w > 4'd8) begin
         return 8;
      end
      return int'(w);
   endfunction

   function automatic logic [WIDTH_W-1:0] random_width();
      if ($urandom_range(9) == 0) begin
         return WIDTH_W'($urandom_range(15));
      end
      return WIDTH_W'($urandom_range(8, 1));
   endfunction

   task automatic repack_item(input logic [SYM_W-1:0] sym, input logic last,
                              output sym_result_type res [8], output int n);
      int iw;
      int ow;
      int bits;
      int cnt;
      iw   = clip_width(cfg_in_width);
      ow   = clip_width(cfg_out_width);
      bits = (int'(pend_bits) | ((int'(sym) & ((1 << iw) - 1)) << int'(pend_cnt)))
             & 32'h7FFF;
      cnt  = int'(pend_cnt) + iw;
      n    = 0;
      while (cnt >= ow && n < 8) begin
         res[n].sym  = SYM_W'(bits & ((1 << ow) - 1));
         res[n].last = 1'b0;
         bits = bits >> ow;
         cnt  = cnt - ow;
         n++;
      end
      if (last) begin
         if (cnt > 0 && n < 8) begin
            res[n].sym  = SYM_W'(bits & ((1 << (cnt & 7)) - 1));
            res[n].last = 1'b1;
            n++;
         end else if (n > 0) begin
            res[n-1].last = 1'b1;
         end
         bits = 0;
         cnt  = 0;
      end
      pend_bits = bits[14:0];
      pend_cnt  = cnt[3:0];
   endtask

   task automatic send_item(input logic [SYM_W-1:0] sym, input logic last,
                            input logic use_typed, input sym_result_type typed_res);
      sym_result_type res [8];
      int             n;
      while (!quiet_run && $urandom_range(99) < STALL_PCT) begin
         req_valid     <= 1'b0;
         req_in_symbol <= SYM_W'($urandom_range(255));
         req_in_last   <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_symbol <= sym;
      req_in_last   <= last;
      do @(posedge clock); while (req_stall);
      repack_item(sym, last, res, n);
      if (use_typed) begin
         pending_syms.push_front(typed_res);
      end else begin
         for (int i = 0; i < n; i++) begin
            pending_syms.push_front(res[i]);
         end
      end
   endtask

   task automatic set_widths(input logic [WIDTH_W-1:0] iw, input logic [WIDTH_W-1:0] ow);
      csr_valid <= 1'b1;
      csr_index <= CSR_IN_WIDTH;
      csr_wdata <= iw;
      do @(posedge clock); while (!csr_ready);
      cfg_in_width = iw;
      csr_index <= CSR_OUT_WIDTH;
      csr_wdata <= ow;
      do @(posedge clock); while (!csr_ready);
      cfg_out_width = ow;
      csr_valid <= 1'b0;
   endtask

   // wait for every pending result, then let the block settle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_syms.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= !quiet_run && ($urandom_range(99) < STALL_PCT);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_syms.size() == 0) begin
               $display("%0t: unexpected item symbol=%h last=%b", $time,
                        rsp_out_symbol, rsp_out_last);
               fail_cnt++;
            end else begin
               head_res = pending_syms.pop_back();
               if (rsp_out_symbol !== head_res.sym) begin
                  $display("%0t: out_symbol expected %h actual %h", $time,
                           head_res.sym, rsp_out_symbol);
                  fail_cnt++;
               end
               if (rsp_out_last !== head_res.last) begin
                  $display("%0t: out_last expected %b actual %b", $time,
                           head_res.last, rsp_out_last);
                  fail_cnt++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int   total;
      int   phase;
      int   len;
      logic last_flag;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_in_symbol <= '0;
      req_in_last   <= 1'b0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_IN_WIDTH;
      csr_wdata     <= '0;
      cfg_in_width  = 4'd8;
      cfg_out_width = 4'd8;
      pend_bits     = '0;
      pend_cnt      = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < NUM_DIR; k++) begin
         if (dir_rows[k].cfg) begin
            drain_block();
            set_widths(dir_rows[k].iw, dir_rows[k].ow);
         end
         send_item(dir_rows[k].sym, dir_rows[k].last, dir_rows[k].typed,
                   {dir_rows[k].exp_sym, dir_rows[k].exp_last});
      end

      // random phases; a phase may end mid-stream so pending bits cross a width change
      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         drain_block();
         quiet_run = (phase == 3);
         set_widths(random_width(), random_width());
         len = quiet_run ? 60 : $urandom_range(40, 4);
         if (len > RANDOM_ITEMS - total) begin
            len = RANDOM_ITEMS - total;
         end
         for (int i = 0; i < len; i++) begin
            if (i == len - 1) begin
               last_flag = ($urandom_range(9) < 7);
            end else begin
               last_flag = ($urandom_range(7) == 0);
            end
            send_item(SYM_W'($urandom_range(255)), last_flag, 1'b0, '0);
            total++;
         end
         quiet_run = 1'b0;
         phase++;
      end

      drain_block();
      if (fail_cnt == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/bwr_pkg.sv
hw/rtl/bwr_front.sv
hw/rtl/bwr_queue.sv
hw/rtl/bwr_back.sv
hw/rtl/bit_width_repacker.sv
sim/bit_width_repacker_test.sv
